/* rtl/qoh_pkg.sv */
// Shared types, constants and helper functions for the orientation histogram unit.
// No dependencies; used by the controller, datapath, top level and testbench.
package qoh_pkg;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HAM,
    ST_DRAIN,
    ST_CORDIC_INIT,
    ST_CORDIC,
    ST_ANGLE,
    ST_BIN_A,
    ST_BIN_B,
    ST_BIN_W,
    ST_INDEX,
    ST_INDEX_W,
    ST_MEM_RD,
    ST_MEM_WAIT,
    ST_DONE
  } qoh_state_t;

  // what the shared multiplier is working on, in the cycle after the issue
  typedef enum logic [2:0] {
    MT_NONE,
    MT_HAM,
    MT_ALPHA,
    MT_BETA,
    MT_INDEX
  } qoh_mtag_t;

  // operation codes of an input word
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // register indexes on the config port
  localparam logic [2:0] REG_AXIS_SELECT = 3'd0;
  localparam logic [2:0] REG_BINS_ALPHA  = 3'd1;
  localparam logic [2:0] REG_BINS_BETA   = 3'd2;
  localparam logic [2:0] REG_ALPHA_MIN   = 3'd3;
  localparam logic [2:0] REG_ALPHA_BPR   = 3'd4;
  localparam logic [2:0] REG_BETA_MIN    = 3'd5;
  localparam logic [2:0] REG_BETA_BPU    = 3'd6;

  localparam int          ATAN_ENTRIES = 24;
  localparam logic [5:0]  HAM_LAST     = 6'd47;  // 3 products x 4 parts x 4 terms
  localparam int          IDX_W        = 17;
  localparam logic signed [15:0] ONE_Q14    = 16'sd16384;
  localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [27:0] TWO_PI_Q24  = 28'sd105414357;
  localparam logic [16:0]        TWO_PI_Q13  = 17'd51472;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       ham_issue;
    logic [1:0] phase;
    logic [1:0] comp;
    logic [1:0] term;
    logic       cordic_init;
    logic       cordic_step;
    logic [4:0] cordic_i;
    logic       angle;
    logic       mul_alpha;
    logic       mul_beta;
    logic       mul_index;
    logic       range_chk;
    logic       mem_rd;
    logic       mem_upd;
    logic       clr_step;
  } qoh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic op_read;
  } qoh_status_t;

  // one result word
  typedef struct packed {
    logic [11:0]        bin_index;
    logic [31:0]        bin_count;
    logic [31:0]        sample_total;
    logic signed [15:0] cos_beta;
    logic [15:0]        alpha_angle;
    logic               out_of_range;
  } qoh_result_t;

  // arctan(2^-i) in 2^-24 rad
  function automatic logic [23:0] atan_q24(input logic [4:0] i);
    logic [23:0] r;
    case (i)
      5'd0:  r = 24'd13176795;
      5'd1:  r = 24'd7778716;
      5'd2:  r = 24'd4110060;
      5'd3:  r = 24'd2086331;
      5'd4:  r = 24'd1047214;
      5'd5:  r = 24'd524117;
      5'd6:  r = 24'd262123;
      5'd7:  r = 24'd131069;
      5'd8:  r = 24'd65536;
      5'd9:  r = 24'd32768;
      5'd10: r = 24'd16384;
      5'd11: r = 24'd8192;
      5'd12: r = 24'd4096;
      5'd13: r = 24'd2048;
      5'd14: r = 24'd1024;
      5'd15: r = 24'd512;
      5'd16: r = 24'd256;
      5'd17: r = 24'd128;
      5'd18: r = 24'd64;
      5'd19: r = 24'd32;
      5'd20: r = 24'd16;
      5'd21: r = 24'd8;
      5'd22: r = 24'd4;
      5'd23: r = 24'd2;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

  // Hamilton product sign: term t of part c is subtracted
  function automatic logic ham_neg(input logic [1:0] c, input logic [1:0] t);
    return (c == 2'd0 && t != 2'd0) || (c == 2'd1 && t == 2'd3) ||
           (c == 2'd2 && t == 2'd1) || (c == 2'd3 && t == 2'd2);
  endfunction

  // Q28 sum to Q2.14, round half up, saturate to +-1.0
  function automatic logic signed [15:0] round_q14(input logic signed [35:0] v);
    logic signed [35:0] s;
    logic signed [21:0] r;
    logic signed [15:0] o;
    s = v + 36'sd8192;
    r = $signed(s[35:14]);
    if (r > 22'sd16384) begin
      o = ONE_Q14;
    end else if (r < -22'sd16384) begin
      o = -ONE_Q14;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

endpackage

/* rtl/qoh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qoh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/qoh_datapath.sv */
// Datapath: shared 17x17 multiplier, Hamilton accumulator, CORDIC, binning, histogram RAM.
// Depends on qoh_pkg and qoh_ram.
module qoh_datapath #(
  parameter int MAX_BINS_ALPHA = 64,
  parameter int MAX_BINS_BETA  = 64,
  parameter int COUNT_WIDTH    = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qoh_pkg::qoh_cmd_t   cmd,
  output qoh_pkg::qoh_status_t status,
  // input word
  input  logic                in_op,
  input  logic signed [15:0]  in_first_w,
  input  logic signed [15:0]  in_first_x,
  input  logic signed [15:0]  in_first_y,
  input  logic signed [15:0]  in_first_z,
  input  logic signed [15:0]  in_second_w,
  input  logic signed [15:0]  in_second_x,
  input  logic signed [15:0]  in_second_y,
  input  logic signed [15:0]  in_second_z,
  input  logic [11:0]         in_read_bin,
  // configuration
  input  logic                axis_select,
  input  logic [6:0]          bins_alpha,
  input  logic [6:0]          bins_beta,
  input  logic [15:0]         alpha_min,
  input  logic [15:0]         alpha_bpr,
  input  logic signed [15:0]  beta_min,
  input  logic signed [15:0]  beta_bpu,
  output qoh_pkg::qoh_result_t result
);

  localparam int DEPTH = MAX_BINS_ALPHA * MAX_BINS_BETA;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = qoh_pkg::IDX_W;

  // captured word
  logic signed [15:0] q1_r [4];
  logic signed [15:0] q2_r [4];
  logic               op_read_r;

  // Hamilton results
  logic signed [15:0] dq_r [4];
  logic signed [15:0] tmp_r [4];
  logic signed [15:0] v_r [4];

  // multiplier pipe
  logic signed [16:0] mul_p, mul_q;
  logic signed [33:0] prod_r;
  qoh_pkg::qoh_mtag_t tag_r;
  logic [1:0]         comp_d_r, term_d_r, phase_d_r;
  logic               neg_d_r;
  logic signed [35:0] acc_r, acc_sum;

  // CORDIC
  logic signed [33:0] cx_r, cy_r;
  logic signed [27:0] cz_r;
  logic               czero_r;
  logic [15:0]        alpha_r;

  // binning
  logic signed [12:0] ial_r;
  logic signed [11:0] ibe_r;
  logic [8:0]         na, nb;
  logic [IW-1:0]      idx_r;
  logic               oor_r;

  // counters and memory
  logic [COUNT_WIDTH-1:0] sample_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] rdata;
  logic [AW-1:0]          clr_addr_r;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;

  assign na = ({2'b0, bins_alpha} > 9'(MAX_BINS_ALPHA)) ? 9'(MAX_BINS_ALPHA)
                                                         : {2'b0, bins_alpha};
  assign nb = ({2'b0, bins_beta} > 9'(MAX_BINS_BETA)) ? 9'(MAX_BINS_BETA)
                                                       : {2'b0, bins_beta};

  // capture the input word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q1_r[0]   <= in_first_w;
      q1_r[1]   <= in_first_x;
      q1_r[2]   <= in_first_y;
      q1_r[3]   <= in_first_z;
      q2_r[0]   <= in_second_w;
      q2_r[1]   <= in_second_x;
      q2_r[2]   <= in_second_y;
      q2_r[3]   <= in_second_z;
      op_read_r <= in_op;
    end
  end

  // multiplier operand select
  always_comb begin
    logic [1:0] k;
    logic [1:0] dsel;
    logic signed [16:0] dq_v;
    k     = cmd.comp ^ cmd.term;
    dsel  = (cmd.phase == 2'd1) ? cmd.term : k;
    dq_v  = {dq_r[dsel][15], dq_r[dsel]};
    mul_p = '0;
    mul_q = '0;
    if (cmd.ham_issue) begin
      case (cmd.phase)
        2'd0: begin
          // dq = q2 * conj(q1)
          mul_p = {q2_r[cmd.term][15], q2_r[cmd.term]};
          mul_q = (k == 2'd0) ? {q1_r[0][15], q1_r[0]}
                              : -{q1_r[k][15], q1_r[k]};
        end
        2'd1: begin
          // conj(dq) * axis
          mul_p = (cmd.term == 2'd0) ? dq_v : -dq_v;
          mul_q = ((axis_select && k == 2'd1) || (!axis_select && k == 2'd3))
                  ? {1'b0, qoh_pkg::ONE_Q14} : 17'sd0;
        end
        2'd2: begin
          // (conj(dq) * axis) * dq
          mul_p = {tmp_r[cmd.term][15], tmp_r[cmd.term]};
          mul_q = dq_v;
        end
        default: begin
          mul_p = '0;
          mul_q = '0;
        end
      endcase
    end else if (cmd.mul_alpha) begin
      mul_p = $signed({1'b0, alpha_r}) - $signed({1'b0, alpha_min});
      mul_q = $signed({1'b0, alpha_bpr});
    end else if (cmd.mul_beta) begin
      mul_p = $signed({v_r[3][15], v_r[3]}) - $signed({beta_min[15], beta_min});
      mul_q = {beta_bpu[15], beta_bpu};
    end else if (cmd.mul_index) begin
      mul_p = $signed({8'b0, na});
      mul_q = {{5{ibe_r[11]}}, ibe_r};
    end
  end

  // product register and its tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= qoh_pkg::MT_NONE;
    end else if (cmd.ham_issue) begin
      tag_r <= qoh_pkg::MT_HAM;
    end else if (cmd.mul_alpha) begin
      tag_r <= qoh_pkg::MT_ALPHA;
    end else if (cmd.mul_beta) begin
      tag_r <= qoh_pkg::MT_BETA;
    end else if (cmd.mul_index) begin
      tag_r <= qoh_pkg::MT_INDEX;
    end else begin
      tag_r <= qoh_pkg::MT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= mul_p * mul_q;
    comp_d_r  <= cmd.comp;
    term_d_r  <= cmd.term;
    phase_d_r <= cmd.phase;
    neg_d_r   <= qoh_pkg::ham_neg(cmd.comp, cmd.term);
  end

  // Hamilton accumulate, write back rounded part after the fourth term
  assign acc_sum = ((term_d_r == 2'd0) ? 36'sd0 : acc_r) +
                   (neg_d_r ? -36'(prod_r) : 36'(prod_r));

  always_ff @(posedge clk) begin
    if (tag_r == qoh_pkg::MT_HAM) begin
      acc_r <= acc_sum;
      if (term_d_r == 2'd3) begin
        case (phase_d_r)
          2'd0:    dq_r[comp_d_r]  <= qoh_pkg::round_q14(acc_sum);
          2'd1:    tmp_r[comp_d_r] <= qoh_pkg::round_q14(acc_sum);
          default: v_r[comp_d_r]   <= qoh_pkg::round_q14(acc_sum);
        endcase
      end
    end
  end

  // CORDIC vectoring, one step per cycle
  always_ff @(posedge clk) begin
    logic signed [33:0] x0, y0, dx, dy;
    logic signed [27:0] at;
    logic signed [27:0] a;
    logic [27:0]        ar;
    x0 = {{2{v_r[1][15]}}, v_r[1], 16'b0};
    y0 = {{2{v_r[2][15]}}, v_r[2], 16'b0};
    dx = cy_r >>> cmd.cordic_i;
    dy = cx_r >>> cmd.cordic_i;
    at = $signed({4'b0, qoh_pkg::atan_q24(cmd.cordic_i)});
    a  = (cz_r < 0) ? cz_r + qoh_pkg::TWO_PI_Q24 : cz_r;
    ar = 28'(a + 28'sd1024);
    if (cmd.cordic_init) begin
      czero_r <= (v_r[1] == 16'sd0) && (v_r[2] == 16'sd0);
      if (x0 < 0) begin
        // pre-rotate into the right half plane
        if (y0 >= 0) begin
          cx_r <= y0;
          cy_r <= -x0;
          cz_r <= qoh_pkg::HALF_PI_Q24;
        end else begin
          cx_r <= -y0;
          cy_r <= x0;
          cz_r <= -qoh_pkg::HALF_PI_Q24;
        end
      end else begin
        cx_r <= x0;
        cy_r <= y0;
        cz_r <= 28'sd0;
      end
    end else if (cmd.cordic_step) begin
      if (cy_r >= 0) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + at;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - at;
      end
    end
    // wrap to [0,2pi) and round to Q3.13; a result of 2pi folds to zero
    if (cmd.angle) begin
      if (czero_r || ({6'b0, ar[27:11]} >= 23'(qoh_pkg::TWO_PI_Q13))) begin
        alpha_r <= 16'd0;
      end else begin
        alpha_r <= ar[26:11];
      end
    end
  end

  // bin indexes from the multiplier
  always_ff @(posedge clk) begin
    if (tag_r == qoh_pkg::MT_ALPHA) begin
      ial_r <= $signed(prod_r[33:21]);
    end
    if (tag_r == qoh_pkg::MT_BETA) begin
      ibe_r <= $signed(prod_r[33:22]);
    end
  end

  // flat index and out-of-range flag
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= IW'(in_read_bin);
      oor_r <= ({{(32 - 12){1'b0}}, in_read_bin} >= 32'(DEPTH));
    end else begin
      if (cmd.range_chk) begin
        oor_r <= !((ial_r >= 0) && (ial_r < $signed({4'b0, na})) &&
                   (ibe_r >= 0) && (ibe_r < $signed({3'b0, nb})));
      end
      if (tag_r == qoh_pkg::MT_INDEX) begin
        idx_r <= prod_r[IW-1:0] + {{(IW - 13){ial_r[12]}}, ial_r};
      end
    end
  end

  // sample counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else if (cmd.accept && in_op == qoh_pkg::OP_ACCUM) begin
      sample_r <= sample_r + 1'b1;
    end
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign status.clr_done = (clr_addr_r == AW'(DEPTH - 1));
  assign status.op_read  = op_read_r;

  // histogram memory: clear sweep or read-modify-write of one bin
  assign ram_we    = cmd.clr_step ||
                     (cmd.mem_upd && op_read_r == qoh_pkg::OP_ACCUM && !oor_r);
  assign ram_waddr = cmd.clr_step ? clr_addr_r : idx_r[AW-1:0];
  assign ram_wdata = cmd.clr_step ? '0 : rdata + 1'b1;

  qoh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.mem_rd),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.mem_upd) begin
      if (oor_r) begin
        cnt_r <= '0;
      end else if (op_read_r == qoh_pkg::OP_READ) begin
        cnt_r <= rdata;
      end else begin
        cnt_r <= rdata + 1'b1;
      end
    end
  end

  // result word
  always_comb begin
    logic [63:0] cnt_ext, smp_ext;
    cnt_ext = 64'(cnt_r);
    smp_ext = 64'(sample_r);
    result.bin_count    = cnt_ext[31:0];
    result.sample_total = smp_ext[31:0];
    result.out_of_range = oor_r;
    if (op_read_r == qoh_pkg::OP_READ) begin
      result.bin_index   = idx_r[11:0];
      result.cos_beta    = 16'sd0;
      result.alpha_angle = 16'd0;
    end else begin
      result.bin_index   = oor_r ? 12'd0 : idx_r[11:0];
      result.cos_beta    = v_r[3];
      result.alpha_angle = alpha_r;
    end
  end

endmodule

/* rtl/qoh_ctrl.sv */
// Controller: sequences the Hamilton products, CORDIC, binning and histogram update.
// Depends on qoh_pkg.
module qoh_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_op,
  input  logic                 out_free,
  input  qoh_pkg::qoh_status_t status,
  output logic                 in_stall,
  output logic                 out_load,
  output qoh_pkg::qoh_cmd_t    cmd
);

  localparam int NSTEP = (CORDIC_STEPS < qoh_pkg::ATAN_ENTRIES) ? CORDIC_STEPS
                                                                : qoh_pkg::ATAN_ENTRIES;

  qoh_pkg::qoh_state_t state_r, state_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic                accept;

  assign in_stall = (state_r != qoh_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qoh_pkg::ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      qoh_pkg::ST_CLEAR: begin
        if (status.clr_done) begin
          state_nxt = qoh_pkg::ST_IDLE;
        end
      end
      qoh_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = (in_op == qoh_pkg::OP_READ) ? qoh_pkg::ST_MEM_RD : qoh_pkg::ST_HAM;
        end
      end
      qoh_pkg::ST_HAM: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == qoh_pkg::HAM_LAST) begin
          state_nxt = qoh_pkg::ST_DRAIN;
        end
      end
      qoh_pkg::ST_DRAIN:       state_nxt = qoh_pkg::ST_CORDIC_INIT;
      qoh_pkg::ST_CORDIC_INIT: begin
        cnt_nxt   = '0;
        state_nxt = qoh_pkg::ST_CORDIC;
      end
      qoh_pkg::ST_CORDIC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'(NSTEP - 1)) begin
          state_nxt = qoh_pkg::ST_ANGLE;
        end
      end
      qoh_pkg::ST_ANGLE:    state_nxt = qoh_pkg::ST_BIN_A;
      qoh_pkg::ST_BIN_A:    state_nxt = qoh_pkg::ST_BIN_B;
      qoh_pkg::ST_BIN_B:    state_nxt = qoh_pkg::ST_BIN_W;
      qoh_pkg::ST_BIN_W:    state_nxt = qoh_pkg::ST_INDEX;
      qoh_pkg::ST_INDEX:    state_nxt = qoh_pkg::ST_INDEX_W;
      qoh_pkg::ST_INDEX_W:  state_nxt = qoh_pkg::ST_MEM_RD;
      qoh_pkg::ST_MEM_RD:   state_nxt = qoh_pkg::ST_MEM_WAIT;
      qoh_pkg::ST_MEM_WAIT: state_nxt = qoh_pkg::ST_DONE;
      qoh_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = qoh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qoh_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.phase    = cnt_r[5:4];
    cmd.comp     = cnt_r[3:2];
    cmd.term     = cnt_r[1:0];
    cmd.cordic_i = cnt_r[4:0];
    out_load     = 1'b0;
    case (state_r)
      qoh_pkg::ST_CLEAR:       cmd.clr_step    = 1'b1;
      qoh_pkg::ST_HAM:         cmd.ham_issue   = 1'b1;
      qoh_pkg::ST_CORDIC_INIT: cmd.cordic_init = 1'b1;
      qoh_pkg::ST_CORDIC:      cmd.cordic_step = 1'b1;
      qoh_pkg::ST_ANGLE:       cmd.angle       = 1'b1;
      qoh_pkg::ST_BIN_A:       cmd.mul_alpha   = 1'b1;
      qoh_pkg::ST_BIN_B:       cmd.mul_beta    = 1'b1;
      qoh_pkg::ST_INDEX: begin
        cmd.mul_index = 1'b1;
        cmd.range_chk = 1'b1;
      end
      qoh_pkg::ST_MEM_RD:      cmd.mem_rd      = 1'b1;
      qoh_pkg::ST_MEM_WAIT:    cmd.mem_upd     = 1'b1;
      qoh_pkg::ST_DONE:        out_load        = out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/quaternion_orientation_histogram_unit.sv */
// Relative orientation histogram unit: an accumulate word (op 0) computes the
// relative rotation of two Q2.14 quaternions on one shared 17x17 multiplier
// (48 products, one per cycle), runs a CORDIC azimuth of CORDIC_STEPS steps
// (capped at the arctan table size), bins the result and updates one counter of
// the histogram RAM. A read word (op 1) goes straight to the histogram read. One
// word is in work at a time; the result register lets the next word in while a
// result waits. After reset the MAX_BINS_ALPHA*MAX_BINS_BETA counters (4096 at
// the defaults) of the histogram are swept to zero before the first word is
// taken; the APB port is live throughout. Write registers only while the unit
// is idle.
module quaternion_orientation_histogram_unit #(
  parameter int MAX_BINS_ALPHA = 64,
  parameter int MAX_BINS_BETA  = 64,
  parameter int COUNT_WIDTH    = 32,
  parameter int CORDIC_STEPS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic signed [15:0] in_first_w,
  input  logic signed [15:0] in_first_x,
  input  logic signed [15:0] in_first_y,
  input  logic signed [15:0] in_first_z,
  input  logic signed [15:0] in_second_w,
  input  logic signed [15:0] in_second_x,
  input  logic signed [15:0] in_second_y,
  input  logic signed [15:0] in_second_z,
  input  logic [11:0]        in_read_bin,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_bin_index,
  output logic [31:0]        out_bin_count,
  output logic [31:0]        out_sample_total,
  output logic signed [15:0] out_cos_beta,
  output logic [15:0]        out_alpha_angle,
  output logic               out_out_of_range,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic               axis_sel_r;
  logic [6:0]         bins_alpha_r, bins_beta_r;
  logic [15:0]        alpha_min_r, alpha_bpr_r;
  logic signed [15:0] beta_min_r, beta_bpu_r;

  qoh_pkg::qoh_cmd_t    cmd;
  qoh_pkg::qoh_status_t status;
  qoh_pkg::qoh_result_t result, res_r;
  logic                 out_valid_r, out_free, out_load;
  logic [2:0]           reg_idx;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_sel_r   <= 1'b0;
      bins_alpha_r <= 7'd1;
      bins_beta_r  <= 7'd1;
      alpha_min_r  <= 16'd0;
      alpha_bpr_r  <= 16'd41;
      beta_min_r   <= 16'sd16384;
      beta_bpu_r   <= -16'sd128;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        qoh_pkg::REG_AXIS_SELECT: axis_sel_r   <= pwdata[0];
        qoh_pkg::REG_BINS_ALPHA:  bins_alpha_r <= pwdata[6:0];
        qoh_pkg::REG_BINS_BETA:   bins_beta_r  <= pwdata[6:0];
        qoh_pkg::REG_ALPHA_MIN:   alpha_min_r  <= pwdata[15:0];
        qoh_pkg::REG_ALPHA_BPR:   alpha_bpr_r  <= pwdata[15:0];
        qoh_pkg::REG_BETA_MIN:    beta_min_r   <= pwdata[15:0];
        qoh_pkg::REG_BETA_BPU:    beta_bpu_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      qoh_pkg::REG_AXIS_SELECT: prdata = {31'b0, axis_sel_r};
      qoh_pkg::REG_BINS_ALPHA:  prdata = {25'b0, bins_alpha_r};
      qoh_pkg::REG_BINS_BETA:   prdata = {25'b0, bins_beta_r};
      qoh_pkg::REG_ALPHA_MIN:   prdata = {16'b0, alpha_min_r};
      qoh_pkg::REG_ALPHA_BPR:   prdata = {16'b0, alpha_bpr_r};
      qoh_pkg::REG_BETA_MIN:    prdata = {16'b0, beta_min_r};
      qoh_pkg::REG_BETA_BPU:    prdata = {16'b0, beta_bpu_r};
      default:                  prdata = 32'b0;
    endcase
  end

  qoh_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .out_free (out_free),
    .status   (status),
    .in_stall (in_stall),
    .out_load (out_load),
    .cmd      (cmd)
  );

  qoh_datapath #(
    .MAX_BINS_ALPHA (MAX_BINS_ALPHA),
    .MAX_BINS_BETA  (MAX_BINS_BETA),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_op       (in_op),
    .in_first_w  (in_first_w),
    .in_first_x  (in_first_x),
    .in_first_y  (in_first_y),
    .in_first_z  (in_first_z),
    .in_second_w (in_second_w),
    .in_second_x (in_second_x),
    .in_second_y (in_second_y),
    .in_second_z (in_second_z),
    .in_read_bin (in_read_bin),
    .axis_select (axis_sel_r),
    .bins_alpha  (bins_alpha_r),
    .bins_beta   (bins_beta_r),
    .alpha_min   (alpha_min_r),
    .alpha_bpr   (alpha_bpr_r),
    .beta_min    (beta_min_r),
    .beta_bpu    (beta_bpu_r),
    .result      (result)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bin_index    = res_r.bin_index;
  assign out_bin_count    = res_r.bin_count;
  assign out_sample_total = res_r.sample_total;
  assign out_cos_beta     = res_r.cos_beta;
  assign out_alpha_angle  = res_r.alpha_angle;
  assign out_out_of_range = res_r.out_of_range;

endmodule

/* rtl/qoh_checker.sv */
// Port-level checker for the orientation histogram unit, bound to the top level.
// Depends on quaternion_orientation_histogram_unit ports only.
module qoh_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [11:0]        out_bin_index,
  input logic [31:0]        out_bin_count,
  input logic [15:0]        out_alpha_angle,
  input logic               out_out_of_range
);

  // a stalled word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bin_count) &&
                               $stable(out_bin_index))
    else $error("stalled result word changed");

  // skipped samples and bad reads report no count
  a_oor_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_bin_count == 32'd0)
    else $error("out-of-range word with nonzero count");

  // azimuth stays below 2pi
  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alpha_angle < 16'd51472)
    else $error("azimuth out of range");

  // reset clears out_valid
  a_no_early_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");

endmodule

bind quaternion_orientation_histogram_unit qoh_checker u_qoh_checker (.*);

/* tb/quaternion_orientation_histogram_unit_test.sv */
// Self-checking testbench for the orientation histogram unit: directed table, then random
// words over several register settings; results checked against typed rows or the model.
// Depends on rtl/qoh_pkg.sv and rtl/quaternion_orientation_histogram_unit.sv.
module quaternion_orientation_histogram_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_BINS = 4096;
  localparam int MAX_BINS = 64;
  localparam int DOG_LIMIT = 20000;
  localparam int PHASE_WORDS = 260;
  localparam longint HALF_PI = 26353589;
  localparam longint TWO_PI = 105414357;
  localparam longint TWO_PI_A = 51472;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = qoh_pkg::OP_ACCUM;
  logic signed [15:0] in_first_w = '0, in_first_x = '0, in_first_y = '0, in_first_z = '0;
  logic signed [15:0] in_second_w = '0, in_second_x = '0, in_second_y = '0, in_second_z = '0;
  logic [11:0] in_read_bin = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] out_bin_index;
  logic [31:0] out_bin_count, out_sample_total;
  logic signed [15:0] out_cos_beta;
  logic [15:0] out_alpha_angle;
  logic out_out_of_range;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  quaternion_orientation_histogram_unit DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model of the histogram and its registers
  logic [31:0] hist_count [HIST_BINS];
  logic [31:0] sample_cnt;
  logic cfg_axis;
  logic [6:0] cfg_bins_a, cfg_bins_b;
  logic [15:0] cfg_alpha_min, cfg_alpha_bpr;
  logic signed [15:0] cfg_beta_min, cfg_beta_bpu;

  qoh_pkg::qoh_result_t pending_results[$];
  int errors = 0;
  int n_samples = 0, n_reads = 0, n_missed = 0, n_phases = 0;
  bit quiet = 1'b0;

  const longint arctan_tab[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
    262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};

  function automatic longint sat_q14(longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic void qmul(input longint p[4], input longint q[4], output longint r[4]);
    r[0] = sat_q14(p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3]);
    r[1] = sat_q14(p[0]*q[1] + p[1]*q[0] + p[2]*q[3] - p[3]*q[2]);
    r[2] = sat_q14(p[0]*q[2] - p[1]*q[3] + p[2]*q[0] + p[3]*q[1]);
    r[3] = sat_q14(p[0]*q[3] + p[1]*q[2] - p[2]*q[1] + p[3]*q[0]);
  endfunction

  // CORDIC azimuth, Q3.13 radians in [0, 2pi)
  function automatic longint azimuth(longint vx, longint vy);
    longint x, y, z, t, dx, dy, q;
    if (vx == 0 && vy == 0) return 0;
    x = vx * 65536; y = vy * 65536; z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI;
      end else begin
        x = -y; y = t; z = -HALF_PI;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_tab[i];
      end else begin
        x -= dx; y += dy; z -= arctan_tab[i];
      end
    end
    while (z < 0) z += TWO_PI;
    while (z >= TWO_PI) z -= TWO_PI;
    q = (z + 1024) >>> 11;
    if (q >= TWO_PI_A) q = 0;
    return q;
  endfunction

  // expected result of one accepted word; updates the model state
  function automatic qoh_pkg::qoh_result_t histogram_step(logic op, logic [3:0][15:0] qa,
                                                          logic [3:0][15:0] qb,
                                                          logic [11:0] rb);
    qoh_pkg::qoh_result_t r;
    longint a1c[4], b2[4], dq[4], dqc[4], ax[4], tmp[4], v[4];
    longint alpha, ial, ibe, na, nb, idx;
    r = '0;
    if (op == qoh_pkg::OP_READ) begin
      r.bin_index = rb;
      r.bin_count = hist_count[rb];
      r.sample_total = sample_cnt;
      return r;
    end
    a1c[0] = $signed(qa[3]); a1c[1] = -$signed(qa[2]);
    a1c[2] = -$signed(qa[1]); a1c[3] = -$signed(qa[0]);
    b2[0] = $signed(qb[3]); b2[1] = $signed(qb[2]);
    b2[2] = $signed(qb[1]); b2[3] = $signed(qb[0]);
    qmul(b2, a1c, dq);
    dqc[0] = dq[0]; dqc[1] = -dq[1]; dqc[2] = -dq[2]; dqc[3] = -dq[3];
    ax = '{0, 0, 0, 0};
    if (cfg_axis) ax[1] = 16384;
    else ax[3] = 16384;
    qmul(dqc, ax, tmp);
    qmul(tmp, dq, v);
    alpha = azimuth(v[1], v[2]);
    sample_cnt = sample_cnt + 1;
    ial = ((alpha - longint'(cfg_alpha_min)) * longint'(cfg_alpha_bpr)) >>> 21;
    ibe = ((v[3] - longint'(cfg_beta_min)) * longint'(cfg_beta_bpu)) >>> 22;
    na = (cfg_bins_a > MAX_BINS) ? MAX_BINS : cfg_bins_a;
    nb = (cfg_bins_b > MAX_BINS) ? MAX_BINS : cfg_bins_b;
    if (ial >= 0 && ial < na && ibe >= 0 && ibe < nb) begin
      idx = na * ibe + ial;
      hist_count[idx] = hist_count[idx] + 1;
      r.bin_index = idx[11:0];
      r.bin_count = hist_count[idx];
    end else begin
      r.out_of_range = 1'b1;
    end
    r.sample_total = sample_cnt;
    r.cos_beta = v[3][15:0];
    r.alpha_angle = alpha[15:0];
    return r;
  endfunction

  // result monitor
  always @(posedge clk) begin
    qoh_pkg::qoh_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_bin_index !== e.bin_index) begin
          $error("bin_index exp %0d got %0d", e.bin_index, out_bin_index); errors++;
        end
        if (out_bin_count !== e.bin_count) begin
          $error("bin_count exp %0d got %0d", e.bin_count, out_bin_count); errors++;
        end
        if (out_sample_total !== e.sample_total) begin
          $error("sample_total exp %0d got %0d", e.sample_total, out_sample_total); errors++;
        end
        if (out_cos_beta !== e.cos_beta) begin
          $error("cos_beta exp %0d got %0d", e.cos_beta, out_cos_beta); errors++;
        end
        if (out_alpha_angle !== e.alpha_angle) begin
          $error("alpha_angle exp %0d got %0d", e.alpha_angle, out_alpha_angle); errors++;
        end
        if (out_out_of_range !== e.out_of_range) begin
          $error("out_of_range exp %0d got %0d", e.out_of_range, out_out_of_range); errors++;
        end
        if (e.out_of_range) n_missed++;
      end
    end
  end

  // receiver stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without an accepted word, a taken result or a register access
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles <= 0;
    else if (idle_cycles >= DOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      qoh_pkg::REG_AXIS_SELECT: cfg_axis = val[0];
      qoh_pkg::REG_BINS_ALPHA: cfg_bins_a = val[6:0];
      qoh_pkg::REG_BINS_BETA: cfg_bins_b = val[6:0];
      qoh_pkg::REG_ALPHA_MIN: cfg_alpha_min = val[15:0];
      qoh_pkg::REG_ALPHA_BPR: cfg_alpha_bpr = val[15:0];
      qoh_pkg::REG_BETA_MIN: cfg_beta_min = val[15:0];
      qoh_pkg::REG_BETA_BPU: cfg_beta_bpu = val[15:0];
      default: ;
    endcase
  endtask

  // present one word and hold it until taken; returns the predicted result
  task automatic send_word(logic op, logic [3:0][15:0] qa, logic [3:0][15:0] qb,
                           logic [11:0] rb, output qoh_pkg::qoh_result_t r);
    in_valid <= 1'b1; in_op <= op;
    in_first_w <= qa[3]; in_first_x <= qa[2]; in_first_y <= qa[1]; in_first_z <= qa[0];
    in_second_w <= qb[3]; in_second_x <= qb[2]; in_second_y <= qb[1]; in_second_z <= qb[0];
    in_read_bin <= rb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = histogram_step(op, qa, qb, rb);
    if (op == qoh_pkg::OP_READ) n_reads++;
    else n_samples++;
  endtask

  // after a word: end of phase, an idle burst, or keep valid high
  task automatic after_word(bit last);
    if (last) begin
      in_valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [3:0][15:0] unit_quat();
    real c[4];
    real nrm;
    logic [3:0][15:0] q;
    int k;
    nrm = 0.0;
    for (k = 0; k < 4; k++) begin
      c[k] = real'(int'($urandom_range(0, 32768)) - 16384);
      nrm += c[k] * c[k];
    end
    nrm = $sqrt(nrm);
    if (nrm < 1.0) return {16'sd16384, 48'd0};
    for (k = 0; k < 4; k++) begin
      c[k] = c[k] * 16384.0 / nrm;
      q[k] = 16'($rtoi(c[k] >= 0.0 ? c[k] + 0.5 : c[k] - 0.5));
    end
    return q;
  endfunction

  function automatic logic [3:0][15:0] raw_quat();
    logic [3:0][15:0] q;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 5))
        0: q[k] = 16'sd16384;
        1: q[k] = -16'sd16384;
        default: q[k] = 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
    end
    return q;
  endfunction

  typedef struct packed {
    logic op;
    logic [3:0][15:0] qa;
    logic [3:0][15:0] qb;
    logic [11:0] rb;
    logic typed;
    qoh_pkg::qoh_result_t res;
  } probe_row_t;

  localparam logic [15:0] P1 = 16'sd16384, M1 = -16'sd16384, Z0 = 16'sd0;
  localparam logic [15:0] H7 = 16'sd11585, P5 = 16'sd8192, M5 = -16'sd8192;

  // directed table at the reset register values; typed results only where obvious
  probe_row_t probes[16];

  typedef struct {
    logic [31:0] v[7];
  } reg_set_t;
  reg_set_t settings[7];

  initial begin
    qoh_pkg::qoh_result_t r;
    int lim;
    bit last;
    foreach (hist_count[i]) hist_count[i] = '0;
    sample_cnt = '0;
    cfg_axis = 1'b0; cfg_bins_a = 7'd1; cfg_bins_b = 7'd1; cfg_alpha_min = '0;
    cfg_alpha_bpr = 16'd41; cfg_beta_min = 16'sd16384; cfg_beta_bpu = -16'sd128;

    probes[0] = '{qoh_pkg::OP_ACCUM, {P1,Z0,Z0,Z0}, {P1,Z0,Z0,Z0}, 12'd0, 1'b1,
                  '{12'd0, 32'd1, 32'd1, 16'sd16384, 16'd0, 1'b0}};
    probes[1] = '{qoh_pkg::OP_ACCUM, {P1,Z0,Z0,Z0}, {P1,Z0,Z0,Z0}, 12'd0, 1'b1,
                  '{12'd0, 32'd2, 32'd2, 16'sd16384, 16'd0, 1'b0}};
    probes[2] = '{qoh_pkg::OP_ACCUM, {P1,Z0,Z0,Z0}, {Z0,P1,Z0,Z0}, 12'd0, 1'b1,
                  '{12'd0, 32'd0, 32'd3, -16'sd16384, 16'd0, 1'b1}};
    probes[3] = '{qoh_pkg::OP_READ, {Z0,Z0,Z0,Z0}, {Z0,Z0,Z0,Z0}, 12'd0, 1'b1,
                  '{12'd0, 32'd2, 32'd3, 16'sd0, 16'd0, 1'b0}};
    probes[4] = '{qoh_pkg::OP_READ, {M1,M1,M1,M1}, {P1,P1,P1,P1}, 12'd4095, 1'b1,
                  '{12'd4095, 32'd0, 32'd3, 16'sd0, 16'd0, 1'b0}};
    probes[5] = '{qoh_pkg::OP_ACCUM, {Z0,Z0,Z0,Z0}, {Z0,Z0,Z0,Z0}, 12'd0, 1'b1,
                  '{12'd0, 32'd3, 32'd4, 16'sd0, 16'd0, 1'b0}};
    probes[6] = '{qoh_pkg::OP_ACCUM, {P1,P1,P1,P1}, {M1,M1,M1,M1}, 12'hFFF, 1'b0, '0};
    probes[7] = '{qoh_pkg::OP_ACCUM, {M1,M1,M1,M1}, {P1,P1,P1,P1}, 12'd0, 1'b0, '0};
    probes[8] = '{qoh_pkg::OP_ACCUM, {P1,Z0,Z0,Z0}, {Z0,Z0,P1,Z0}, 12'd0, 1'b0, '0};
    probes[9] = '{qoh_pkg::OP_ACCUM, {P1,Z0,Z0,Z0}, {H7,Z0,Z0,H7}, 12'd0, 1'b0, '0};
    probes[10] = '{qoh_pkg::OP_ACCUM, {P1,Z0,Z0,Z0}, {H7,H7,Z0,Z0}, 12'd0, 1'b0, '0};
    probes[11] = '{qoh_pkg::OP_ACCUM, {Z0,Z0,Z0,P1}, {H7,Z0,H7,Z0}, 12'd0, 1'b0, '0};
    probes[12] = '{qoh_pkg::OP_ACCUM, {M1,Z0,Z0,Z0}, {P1,Z0,Z0,Z0}, 12'd0, 1'b0, '0};
    probes[13] = '{qoh_pkg::OP_READ, {Z0,Z0,Z0,Z0}, {Z0,Z0,Z0,Z0}, 12'd1, 1'b0, '0};
    probes[14] = '{qoh_pkg::OP_ACCUM, {P5,M5,P5,M5}, {M5,P5,P5,P5}, 12'd0, 1'b0, '0};
    probes[15] = '{qoh_pkg::OP_READ, {Z0,Z0,Z0,Z0}, {Z0,Z0,Z0,Z0}, 12'd0, 1'b0, '0};

    // axis, bins alpha, bins beta, alpha min, alpha bins/rad, beta min, beta bins/unit
    settings[0].v = '{0, 8, 8, 0, 326, 32'h4000, 32'hFC00};
    settings[1].v = '{1, 8, 8, 0, 326, 32'h4000, 32'hFC00};
    settings[2].v = '{0, 64, 64, 0, 2607, 32'h4000, 32'hE000};
    settings[3].v = '{1, 127, 100, 51472, 65535, 32'hC000, 32'h7FFF};
    settings[4].v = '{0, 0, 5, 12000, 1000, 32'hC000, 32'h7FFF};
    settings[5].v = '{1, 3, 64, 25736, 0, 0, 32'h8000};
    settings[6].v = '{1, 16, 4, 0, 652, 32'h4000, 32'hFE00};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (probes[i]) begin
      send_word(probes[i].op, probes[i].qa, probes[i].qb, probes[i].rb, r);
      pending_results.push_back(probes[i].typed ? probes[i].res : r);
      after_word(i == 15);
    end

    // random phases, each at one register setting; the sender drains between them
    foreach (settings[p]) begin
      wait_drained();
      for (int k = 0; k < 7; k++) write_reg(3'(k), settings[p].v[k]);
      n_phases++;
      lim = PHASE_WORDS;
      for (int n = 0; n < lim; n++) begin
        logic op;
        logic [3:0][15:0] qa, qb;
        int pick;
        if (p == 6 && n == lim / 2) quiet = 1'b1;
        pick = $urandom_range(0, 99);
        op = (pick < 15) ? qoh_pkg::OP_READ : qoh_pkg::OP_ACCUM;
        qa = (pick >= 15 && pick < 30) ? raw_quat() : unit_quat();
        qb = (pick >= 15 && pick < 30) ? raw_quat() : unit_quat();
        last = (n == lim - 1);
        send_word(op, qa, qb, 12'($urandom_range(0, 4095)), r);
        pending_results.push_back(r);
        after_word(last);
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    $display("Covered %0d samples and %0d bin reads over %0d register settings,",
             n_samples, n_reads, n_phases);
    $display("%0d samples fell outside the binned ranges.", n_missed);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/qoh_pkg.sv
rtl/qoh_ram.sv
rtl/qoh_datapath.sv
rtl/qoh_ctrl.sv
rtl/quaternion_orientation_histogram_unit.sv
rtl/qoh_checker.sv
tb/quaternion_orientation_histogram_unit_test.sv
